// ===== design/ncet_pkg.sv =====
// ---------------------------------------------------------------------------
// ncet_pkg
// Shared types and constants for the nested call exclusive time profiler.
// ---------------------------------------------------------------------------
package ncet_pkg;

    localparam int FUNC_ID_W = 7;
    localparam int STAMP_W   = 30;
    localparam int BOUND_W   = 31;
    localparam int TOTAL_W   = 32;
    localparam int ID_COUNT  = 2 ** FUNC_ID_W;

    localparam logic OP_START = 1'b0;
    localparam logic OP_END   = 1'b1;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2
    } t_status;

    typedef struct packed {
        logic                 op;
        logic [FUNC_ID_W-1:0] func_id;
        logic [STAMP_W-1:0]   stamp;
    } t_event;

    typedef struct packed {
        logic                 credit_valid;
        logic [FUNC_ID_W-1:0] credited_id;
        logic [TOTAL_W-1:0]   credited_total;
        t_status              status;
    } t_result;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_LOOKUP,
        S_ADD,
        S_RESP
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic clear_step;
        logic capture;
        logic decode;
        logic lookup;
        logic commit;
        logic load_out;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic clear_last;
        logic need_credit;
        logic out_free;
    } t_dp_status;

endpackage

// ===== design/nested_call_exclusive_time_core.sv =====
// ---------------------------------------------------------------------------
// nested_call_exclusive_time_core
// Exclusive time profiler for nested calls: start/end events in, one
// credit word out per event.
// ---------------------------------------------------------------------------
//  channel   dir  handshake          word
//  event     in   i_valid / o_stall  i_event  (op, func_id, stamp)
//  result    out  o_valid / i_stall  o_result (credit_valid, credited_id,
//                                              credited_total, status)
//
//  An event that credits a caller goes from accept through decode, stack
//  read, totals read, update and result load before the next accept; a
//  rejected event or a start on an empty stack goes from decode straight
//  to the result load. The one-port stack and totals reads set this order.
//  After reset the totals store is cleared one entry a cycle, all
//  MAX_FUNCS entries, with o_stall held high.
//  A finished word waits in the output register while i_stall is high; the
//  next event is still taken and worked on, but its word is only loaded
//  once the waiting one has moved on.
// ---------------------------------------------------------------------------
module nested_call_exclusive_time_core import ncet_pkg::*; #(
    parameter int MAX_FUNCS   = 128,
    parameter int STACK_DEPTH = 64
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_stall,
    input  t_event  i_event,
    output logic    o_valid,
    input  logic    i_stall,
    output t_result o_result
);

    t_cmd       w_cmd;
    t_dp_status w_status;

    ncet_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_valid),
        .i_status   (w_status),
        .o_in_stall (o_stall),
        .o_cmd      (w_cmd)
    );

    ncet_datapath #(
        .MAX_FUNCS   (MAX_FUNCS),
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_event     (i_event),
        .i_out_stall (i_stall),
        .o_status    (w_status),
        .o_out_valid (o_valid),
        .o_result    (o_result)
    );

    a_credit_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_result.credit_valid |-> o_result.status == ST_OK)
        else $error("credit reported with error status");

    a_no_credit_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_result.credit_valid |->
            (o_result.credited_id == '0) && (o_result.credited_total == '0))
        else $error("uncredited word carries id or total");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("second event taken while one is in progress");

endmodule

// ===== design/ncet_ctrl.sv =====
// ---------------------------------------------------------------------------
// ncet_ctrl
// Sequencer: clears the totals store after reset, then steps each event
// through decode and, when a caller is credited, stack read, totals read and update, then result load.
// ---------------------------------------------------------------------------
module ncet_ctrl import ncet_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  t_dp_status i_status,
    output logic       o_in_stall,
    output t_cmd       o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (i_status.clear_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) n_state = S_DECODE;
            end
            S_DECODE: begin
                // rejected events and a start on an empty stack credit nobody
                n_state = i_status.need_credit ? S_LOOKUP : S_RESP;
            end
            S_LOOKUP: n_state = S_ADD;
            S_ADD:    n_state = S_RESP;
            S_RESP: begin
                if (i_status.out_free) n_state = S_IDLE;
            end
            default:  n_state = S_CLEAR;
        endcase
    end

    always_comb begin
        o_cmd            = '0;
        o_cmd.clear_step = (r_state == S_CLEAR);
        o_cmd.capture    = (r_state == S_IDLE) && i_in_valid;
        o_cmd.decode     = (r_state == S_DECODE);
        o_cmd.lookup     = (r_state == S_LOOKUP);
        o_cmd.commit     = (r_state == S_ADD);
        o_cmd.load_out   = (r_state == S_RESP) && i_status.out_free;
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

// ===== design/ncet_datapath.sv =====
// ---------------------------------------------------------------------------
// ncet_datapath
// Call stack, boundary time, totals store, saturating credit and the
// output word register.
// ---------------------------------------------------------------------------
module ncet_datapath import ncet_pkg::*; #(
    parameter int MAX_FUNCS   = 128,
    parameter int STACK_DEPTH = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cmd       i_cmd,
    input  t_event     i_event,
    input  logic       i_out_stall,
    output t_dp_status o_status,
    output logic       o_out_valid,
    output t_result    o_result
);

    localparam int FW  = $clog2(MAX_FUNCS);
    localparam int SAW = $clog2(STACK_DEPTH);
    localparam int CW  = $clog2(STACK_DEPTH + 1);
    localparam logic [CW-1:0] FullCount = CW'(STACK_DEPTH);
    localparam logic [FW-1:0] LastId    = FW'(MAX_FUNCS - 1);

    logic [FW-1:0]      r_stack_mem [STACK_DEPTH];
    logic [TOTAL_W-1:0] r_total_mem [MAX_FUNCS];

    t_event             r_ev;
    logic [CW-1:0]      r_count;
    logic [BOUND_W-1:0] r_lb;
    logic [BOUND_W-1:0] r_elapsed;
    logic [FW-1:0]      r_stack_q;
    logic [FW-1:0]      r_cid;
    logic [TOTAL_W-1:0] r_total_q;
    logic [FW-1:0]      r_clr_idx;
    t_result            r_res;
    t_result            r_out;
    logic               r_out_valid;

    logic [FW-1:0]      w_id_map [ID_COUNT];
    logic               w_is_end;
    logic               w_empty;
    logic               w_reject;
    logic [BOUND_W-1:0] w_now;
    logic [BOUND_W-1:0] w_elapsed;
    logic [SAW-1:0]     w_top_addr;
    logic [SAW-1:0]     w_push_addr;
    logic [TOTAL_W:0]   w_sum;
    logic [TOTAL_W-1:0] w_sat;

    // id folding table, worked out at elaboration
    for (genvar v = 0; v < ID_COUNT; v++) begin : g_id_map
        assign w_id_map[v] = FW'(v % MAX_FUNCS);
    end

    assign w_is_end    = (r_ev.op == OP_END);
    assign w_empty     = (r_count == '0);
    assign w_reject    = w_is_end ? w_empty : (r_count == FullCount);
    assign w_now       = w_is_end ? ({1'b0, r_ev.stamp} + BOUND_W'(1)) : {1'b0, r_ev.stamp};
    assign w_elapsed   = (w_now > r_lb) ? (w_now - r_lb) : '0;
    assign w_top_addr  = SAW'(r_count - CW'(1));
    assign w_push_addr = r_count[SAW-1:0];
    assign w_sum       = {1'b0, r_total_q} + (TOTAL_W + 1)'(r_elapsed);
    assign w_sat       = w_sum[TOTAL_W] ? '1 : w_sum[TOTAL_W-1:0];

    always_comb begin
        o_status             = '0;
        o_status.clear_last  = (r_clr_idx == LastId);
        o_status.need_credit = !w_reject && !w_empty;
        o_status.out_free    = !r_out_valid || !i_out_stall;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_lb        <= '0;
            r_clr_idx   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clear_step) r_clr_idx <= r_clr_idx + FW'(1);
            if (i_cmd.decode && !w_reject) begin
                r_lb <= w_now;
                if (w_is_end) begin
                    r_count <= r_count - CW'(1);
                end else begin
                    r_count <= r_count + CW'(1);
                end
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) r_ev <= i_event;
        if (i_cmd.decode) begin
            r_elapsed            <= w_elapsed;
            r_res.credit_valid   <= 1'b0;
            r_res.credited_id    <= '0;
            r_res.credited_total <= '0;
            if (!w_reject) begin
                r_res.status <= ST_OK;
            end else begin
                r_res.status <= w_is_end ? ST_UNDERFLOW : ST_OVERFLOW;
            end
        end
        if (i_cmd.lookup) r_cid <= r_stack_q;
        if (i_cmd.commit) begin
            r_res.credit_valid   <= 1'b1;
            r_res.credited_id    <= FUNC_ID_W'(r_cid);
            r_res.credited_total <= w_sat;
            r_res.status         <= ST_OK;
        end
        if (i_cmd.load_out) r_out <= r_res;
    end

    // call stack: push and top read never hit the same entry in one cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.decode && !w_reject && !w_is_end) begin
            r_stack_mem[w_push_addr] <= w_id_map[r_ev.func_id];
        end
        if (i_cmd.decode) r_stack_q <= r_stack_mem[w_top_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clear_step) begin
            r_total_mem[r_clr_idx] <= '0;
        end else if (i_cmd.commit) begin
            r_total_mem[r_cid] <= w_sat;
        end
        if (i_cmd.lookup) r_total_q <= r_total_mem[r_stack_q];
    end

    assign o_out_valid = r_out_valid;
    assign o_result    = r_out;

endmodule

// ===== tb/tb.sv =====
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for nested_call_exclusive_time_core. A clocked driver
// feeds start/end event words from a queue; an in-bench profiler keeps its
// own call stack, boundary time and totals and predicts one credit word per
// accepted event, which a clocked monitor checks as words leave the core.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
    import ncet_pkg::*;

    localparam int NUM_FUNCS    = 128;
    localparam int STACK_LIMIT  = 64;
    localparam int CLK_PERIOD   = 8;
    localparam int RESET_CYCLES = 7;
    localparam int IDLE_PCT     = 34;
    localparam int RANDOM_ITEMS = 1500;
    localparam int QUIET_FIRST  = 700;
    localparam int QUIET_LAST   = 1000;
    localparam int MAX_REPORTS  = 10;
    localparam int DRAIN_CYCLES = 20;
    localparam int HANG_LIMIT   = 4000;
    localparam logic [STAMP_W-1:0] STAMP_MAX = '1;

    logic    i_clk   = 1'b0;
    logic    i_rst_n = 1'b0;
    logic    i_valid = 1'b0;
    logic    i_stall = 1'b0;
    t_event  i_event = '0;
    logic    o_stall;
    logic    o_valid;
    t_result o_result;

    t_event  event_q [$];
    t_result credit_q [$];

    int total_items    = 0;
    int accepted_count = 0;
    int result_count   = 0;
    int error_count    = 0;
    int hang_cycles    = 0;

    // profiler shadow state
    logic [FUNC_ID_W-1:0] shadow_stack [STACK_LIMIT];
    int                   shadow_depth    = 0;
    logic [BOUND_W-1:0]   shadow_boundary = '0;
    logic [TOTAL_W-1:0]   shadow_totals [NUM_FUNCS];

    nested_call_exclusive_time_core #(
        .MAX_FUNCS   (NUM_FUNCS),
        .STACK_DEPTH (STACK_LIMIT)
    ) dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_event  (i_event),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_result (o_result)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Credit time since the last boundary to an id; negative spans give 0.
    function automatic logic [TOTAL_W-1:0] credit_time(logic [FUNC_ID_W-1:0] id,
                                                       logic [BOUND_W-1:0] now);
        logic [TOTAL_W-1:0] amount;
        logic [TOTAL_W:0]   sum;
        amount = '0;
        if (now > shadow_boundary)
            amount = TOTAL_W'(now - shadow_boundary);
        sum = {1'b0, shadow_totals[id]} + {1'b0, amount};
        shadow_totals[id] = sum[TOTAL_W] ? '1 : sum[TOTAL_W-1:0];
        return shadow_totals[id];
    endfunction

    function automatic t_result profile_event(t_event ev);
        t_result            r;
        logic [BOUND_W-1:0] now;
        r = '0;
        r.status = ST_OK;
        if (ev.op == OP_START) begin
            if (shadow_depth >= STACK_LIMIT) begin
                r.status = ST_OVERFLOW;
            end else begin
                if (shadow_depth > 0) begin
                    r.credit_valid   = 1'b1;
                    r.credited_id    = shadow_stack[shadow_depth - 1];
                    r.credited_total = credit_time(r.credited_id, {1'b0, ev.stamp});
                end
                shadow_stack[shadow_depth] = ev.func_id;
                shadow_depth++;
                shadow_boundary = {1'b0, ev.stamp};
            end
        end else begin
            if (shadow_depth == 0) begin
                r.status = ST_UNDERFLOW;
            end else begin
                // func_id of an end word is ignored; the top is popped
                shadow_depth--;
                now = {1'b0, ev.stamp} + BOUND_W'(1);
                r.credit_valid   = 1'b1;
                r.credited_id    = shadow_stack[shadow_depth];
                r.credited_total = credit_time(r.credited_id, now);
                shadow_boundary  = now;
            end
        end
        return r;
    endfunction

    task automatic add_event(logic op, logic [FUNC_ID_W-1:0] id, logic [STAMP_W-1:0] stamp);
        t_event ev;
        ev.op      = op;
        ev.func_id = id;
        ev.stamp   = stamp;
        event_q.push_back(ev);
    endtask

    // Driver: a new word is only presented once the previous one has gone.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                credit_q.push_back(profile_event(i_event));
                accepted_count++;
            end
            if (!i_valid || !o_stall) begin
                if (event_q.size() != 0 &&
                    ((accepted_count >= QUIET_FIRST && accepted_count < QUIET_LAST) ||
                     $urandom_range(99) >= IDLE_PCT)) begin
                    i_event <= event_q.pop_front();
                    i_valid <= 1'b1;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor and receiver stall
    always @(posedge i_clk) begin
        t_result exp_word;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                result_count++;
                if (credit_q.size() == 0) begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                        $display("ERROR: unexpected result word %h", o_result);
                end else begin
                    exp_word = credit_q.pop_front();
                    if (o_result.credit_valid   !== exp_word.credit_valid ||
                        o_result.credited_id    !== exp_word.credited_id ||
                        o_result.credited_total !== exp_word.credited_total ||
                        o_result.status         !== exp_word.status) begin
                        error_count++;
                        if (error_count <= MAX_REPORTS)
                            $display({"ERROR: word %0d exp valid=%b id=%0d total=%0d st=%0d",
                                      " got valid=%b id=%0d total=%0d st=%0d"},
                                     result_count,
                                     exp_word.credit_valid, exp_word.credited_id,
                                     exp_word.credited_total, exp_word.status,
                                     o_result.credit_valid, o_result.credited_id,
                                     o_result.credited_total, o_result.status);
                    end
                end
            end
            if (result_count >= QUIET_FIRST && result_count < QUIET_LAST)
                i_stall <= 1'b0;
            else
                i_stall <= ($urandom_range(99) < IDLE_PCT);
        end
    end

    // Watchdog on handshake progress
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            hang_cycles <= 0;
        end else if (hang_cycles >= HANG_LIMIT) begin
            $display("nested_call_exclusive_time_core verification failed");
            $finish;
        end else begin
            hang_cycles <= hang_cycles + 1;
        end
    end

    initial begin
        logic [STAMP_W-1:0] stamp_clock;
        int                 counted;
        int                 push_pct;
        int                 run_len;
        logic               op;

        foreach (shadow_totals[k])
            shadow_totals[k] = '0;

        // directed: empty-stack end, start on empty, time going backwards,
        // end word id ignored, saturation of a total, extreme ids and stamps
        add_event(OP_END,   7'd127, STAMP_MAX);
        add_event(OP_START, 7'd0,   '0);
        add_event(OP_START, 7'd127, STAMP_MAX);
        add_event(OP_END,   7'd5,   '0);
        add_event(OP_START, 7'd1,   STAMP_MAX);
        add_event(OP_END,   7'd0,   '0);
        add_event(OP_START, 7'd2,   STAMP_MAX);
        add_event(OP_END,   7'd0,   '0);
        add_event(OP_START, 7'd3,   STAMP_MAX);
        add_event(OP_END,   7'd0,   '0);
        add_event(OP_START, 7'd4,   STAMP_MAX);
        add_event(OP_END,   7'd0,   STAMP_MAX);
        add_event(OP_END,   7'd127, STAMP_MAX);
        add_event(OP_END,   7'd0,   '0);
        add_event(OP_START, 7'd85,  30'h2AAAAAAA);
        add_event(OP_START, 7'd42,  30'h15555555);
        add_event(OP_START, 7'd10,  30'd100);
        add_event(OP_END,   7'd0,   30'd100);
        add_event(OP_END,   7'd0,   30'h3FFFFFFE);
        add_event(OP_END,   7'd0,   STAMP_MAX);
        add_event(OP_END,   7'd0,   '0);

        // random: phases biased to deep nesting, unwinding or a mix, with
        // mostly rising stamps and the odd jump anywhere in the range
        stamp_clock = '0;
        counted     = 0;
        while (counted < RANDOM_ITEMS) begin
            case ($urandom_range(2))
                0:       push_pct = 88;
                1:       push_pct = 50;
                default: push_pct = 12;
            endcase
            run_len = $urandom_range(30, 120);
            if (run_len > RANDOM_ITEMS - counted)
                run_len = RANDOM_ITEMS - counted;
            repeat (run_len) begin
                if ($urandom_range(99) < 6)
                    stamp_clock = STAMP_W'($urandom);
                else
                    stamp_clock = stamp_clock + STAMP_W'($urandom_range(0, 40));
                op = ($urandom_range(99) < push_pct) ? OP_START : OP_END;
                add_event(op, FUNC_ID_W'($urandom_range(NUM_FUNCS - 1)), stamp_clock);
                counted++;
            end
        end
        total_items = event_q.size();

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        wait (accepted_count == total_items && credit_q.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (error_count == 0)
            $display("nested_call_exclusive_time_core verification clean");
        else
            $display("nested_call_exclusive_time_core verification failed");
        $finish;
    end

endmodule
